// ===== hw/rtl/scp_pkg.sv =====
package scp_pkg;

  localparam int unsigned NumSectionsDef = 8;
  localparam int unsigned IdxW           = 6;
  localparam int unsigned InDataW        = 48;
  localparam int unsigned OutDataW       = 128;

  localparam logic [31:0] ClkHzReset     = 32'd100000000;
  localparam logic [31:0] CyclesPerUs    = 32'd1000000;
  localparam logic [30:0] UsRecip        = 31'd1125899907;
  localparam int unsigned UsShift        = 50;
  localparam logic [9:0]  TotalLoadMax   = 10'd1000;
  localparam logic [15:0] SectionLoadMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_END_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_REC_RD,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DK_TOT,
    DK_LAST,
    DK_MAX,
    DK_LOAD
  } div_e;

  typedef struct packed {
    logic            in_take;
    logic            beg_wr;
    logic            end_rd;
    logic            end_wr;
    logic            sum_clr;
    logic            sum_rd;
    logic            sum_acc;
    logic            rec_rd;
    logic            div_start;
    logic            div_capture;
    div_e            div_kind;
    logic            out_load;
    logic            out_last;
    logic            acc_clr;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic is_begin;
    logic is_end;
    logic is_tick;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/scp_ram.sv =====
module scp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/scp_div.sv =====
module scp_div #(
  parameter int unsigned DivW = 45
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [31:0]     divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     dvs_q, dvs_d;
  logic [32:0]     shifted;
  logic [32:0]     diff;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        if (!diff[32]) begin
          rem_d = diff[31:0];
          quo_d = {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_d = shifted[31:0];
          quo_d = {quo_q[DivW-2:0], 1'b0};
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/scp_datapath.sv =====
module scp_datapath #(
  parameter int unsigned NumSections = scp_pkg::NumSectionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic [scp_pkg::InDataW-1:0]   s_tdata_i,
  input  scp_pkg::cmd_t                 cmd_i,
  output scp_pkg::sts_t                 sts_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [scp_pkg::OutDataW-1:0]  m_tdata_o,
  output logic                          m_tlast_o
);

  import scp_pkg::*;

  localparam int unsigned SecW = (NumSections > 1) ? $clog2(NumSections) : 1;
  localparam int unsigned SumW = 32 + SecW;
  localparam int unsigned DivW = SumW + 10;

  logic [1:0]  in_op;
  logic [7:0]  in_sec;
  logic [31:0] in_now;
  logic        sec_ok;

  assign in_op  = s_tdata_i[1:0];
  assign in_sec = s_tdata_i[9:2];
  assign in_now = s_tdata_i[41:10];
  assign sec_ok = in_sec < 8'(NumSections);

  logic [31:0]            clk_hz_q;
  logic [31:0]            now_q;
  logic [SecW-1:0]        sec_q;
  logic [SecW-1:0]        rd_idx_q;
  logic [NumSections-1:0] begin_vld_q;
  logic [NumSections-1:0] rec_vld_q;
  logic [NumSections-1:0] acc_vld_q;
  logic [SumW-1:0]        sum_q;
  logic [31:0]            per_us_q;
  logic [9:0]             total_q;
  logic [31:0]            last_us_q;
  logic [31:0]            max_us_q;
  logic [15:0]            load_q;
  logic                   out_vld_q;
  logic [OutDataW-1:0]    out_data_q;
  logic                   out_last_q;

  logic [SecW-1:0]  idx;
  logic [SecW-1:0]  rd_addr;
  logic             rd_en;
  logic [31:0]      stamp_rd;
  logic [127:0]     stats_rd;
  logic [31:0]      stamp_old, last_old, max_old, busy_old, call_old;
  logic [31:0]      dt, max_new, busy_new, call_new;

  assign idx     = cmd_i.idx[SecW-1:0];
  assign rd_en   = cmd_i.end_rd | cmd_i.rec_rd | cmd_i.sum_rd;
  assign rd_addr = cmd_i.end_rd ? in_sec[SecW-1:0] : idx;

  scp_ram #(
    .Width (32),
    .Depth (NumSections)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.beg_wr),
    .waddr_i (in_sec[SecW-1:0]),
    .wdata_i (in_now),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (stamp_rd)
  );

  scp_ram #(
    .Width (128),
    .Depth (NumSections)
  ) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.end_wr),
    .waddr_i (sec_q),
    .wdata_i ({call_new, busy_new, max_new, dt}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (stats_rd)
  );

  assign stamp_old = begin_vld_q[rd_idx_q] ? stamp_rd : '0;
  assign last_old  = rec_vld_q[rd_idx_q] ? stats_rd[31:0] : '0;
  assign max_old   = rec_vld_q[rd_idx_q] ? stats_rd[63:32] : '0;
  assign busy_old  = acc_vld_q[rd_idx_q] ? stats_rd[95:64] : '0;
  assign call_old  = acc_vld_q[rd_idx_q] ? stats_rd[127:96] : '0;

  assign dt       = now_q - stamp_old;
  assign max_new  = (dt > max_old) ? dt : max_old;
  assign busy_new = busy_old + dt;
  assign call_new = call_old + 32'd1;

  logic [DivW-1:0] sum_x, busy_x, tot_prod, busy_prod;
  logic [DivW-1:0] div_dividend;
  logic [31:0]     div_divisor;
  logic [DivW-1:0] quo;
  logic            div_busy, div_done;
  logic [62:0]     us_prod;

  assign sum_x     = DivW'(sum_q);
  assign busy_x    = DivW'(busy_old);
  assign tot_prod  = (sum_x << 10) - (sum_x << 4) - (sum_x << 3);
  assign busy_prod = (busy_x << 10) - (busy_x << 4) - (busy_x << 3);
  assign us_prod   = {31'd0, clk_hz_q} * {32'd0, UsRecip};

  always_comb begin
    div_dividend = '0;
    div_divisor  = clk_hz_q;
    unique case (cmd_i.div_kind)
      DK_TOT:  div_dividend = tot_prod;
      DK_LAST: begin
        div_dividend = DivW'(last_old);
        div_divisor  = per_us_q;
      end
      DK_MAX: begin
        div_dividend = DivW'(max_old);
        div_divisor  = per_us_q;
      end
      DK_LOAD: div_dividend = busy_prod;
      default: div_dividend = '0;
    endcase
  end

  scp_div #(
    .DivW (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q    <= ClkHzReset;
      begin_vld_q <= '0;
      rec_vld_q   <= '0;
      acc_vld_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        clk_hz_q <= cfg_wdata_i;
      end
      if (cmd_i.beg_wr) begin
        begin_vld_q[in_sec[SecW-1:0]] <= 1'b1;
      end
      if (cmd_i.end_wr) begin
        rec_vld_q[sec_q] <= 1'b1;
      end
      if (cmd_i.acc_clr) begin
        acc_vld_q <= '0;
      end else if (cmd_i.end_wr) begin
        acc_vld_q[sec_q] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      now_q <= in_now;
      sec_q <= in_sec[SecW-1:0];
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.sum_clr) begin
      sum_q    <= '0;
      per_us_q <= {19'd0, us_prod[62:UsShift]};
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q + SumW'(busy_old);
    end
    if (cmd_i.div_capture) begin
      unique case (cmd_i.div_kind)
        DK_TOT:  total_q <= (clk_hz_q == '0) ? '0 :
                            (quo > DivW'(TotalLoadMax)) ? TotalLoadMax : quo[9:0];
        DK_LAST: last_us_q <= (per_us_q == '0) ? '0 : quo[31:0];
        DK_MAX:  max_us_q <= (per_us_q == '0) ? '0 : quo[31:0];
        DK_LOAD: load_q <= (clk_hz_q == '0) ? '0 :
                           (quo > DivW'(SectionLoadMax)) ? SectionLoadMax : quo[15:0];
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_data_q <= {total_q, load_q, call_old, max_us_q, last_us_q, cmd_i.idx};
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.is_begin = (in_op == OP_BEGIN) && sec_ok;
  assign sts_o.is_end   = (in_op == OP_END) && sec_ok;
  assign sts_o.is_tick  = (in_op == OP_TICK);
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_vld_q || m_tready_i;

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ===== hw/rtl/scp_ctrl.sv =====
module scp_ctrl #(
  parameter int unsigned NumSections = scp_pkg::NumSectionsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  scp_pkg::sts_t sts_i,
  output scp_pkg::cmd_t cmd_o
);

  import scp_pkg::*;

  localparam int unsigned SecW = (NumSections > 1) ? $clog2(NumSections) : 1;
  localparam logic [SecW-1:0] LastIdx = SecW'(NumSections - 1);

  state_e          state_q, state_d;
  div_e            kind_q, kind_d;
  logic [SecW-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          if (sts_i.is_end) begin
            state_d = ST_END_UPD;
          end else if (sts_i.is_tick) begin
            state_d = ST_SUM_RD;
            idx_d   = '0;
          end
        end
      end
      ST_END_UPD: state_d = ST_IDLE;
      ST_DIV_GO:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          unique case (kind_q)
            DK_TOT: begin
              state_d = ST_REC_RD;
              idx_d   = '0;
            end
            DK_LAST: begin
              state_d = ST_DIV_GO;
              kind_d  = DK_MAX;
            end
            DK_MAX: begin
              state_d = ST_DIV_GO;
              kind_d  = DK_LOAD;
            end
            DK_LOAD: state_d = ST_EMIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUM_RD: state_d = ST_SUM_ACC;
      ST_SUM_ACC: begin
        if (idx_q == LastIdx) begin
          state_d = ST_DIV_GO;
          kind_d  = DK_TOT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SUM_RD;
        end
      end
      ST_REC_RD: begin
        state_d = ST_DIV_GO;
        kind_d  = DK_LAST;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (idx_q == LastIdx) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_REC_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = IdxW'(idx_q);
    cmd_o.div_kind = kind_q;
    s_tready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.in_take = s_tvalid_i;
        cmd_o.beg_wr  = s_tvalid_i && sts_i.is_begin;
        cmd_o.end_rd  = s_tvalid_i && sts_i.is_end;
        cmd_o.sum_clr = s_tvalid_i && sts_i.is_tick;
      end
      ST_END_UPD:  cmd_o.end_wr = 1'b1;
      ST_DIV_GO:   cmd_o.div_start = 1'b1;
      ST_DIV_WAIT: cmd_o.div_capture = sts_i.div_done;
      ST_SUM_RD:   cmd_o.sum_rd = 1'b1;
      ST_SUM_ACC:  cmd_o.sum_acc = 1'b1;
      ST_REC_RD:   cmd_o.rec_rd = 1'b1;
      ST_EMIT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = (idx_q == LastIdx);
        cmd_o.acc_clr  = sts_i.out_free && (idx_q == LastIdx);
      end
      default: cmd_o.in_take = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= DK_TOT;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/section_cycle_profiler_unit.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tdata: op, section_id, now_cycles
// m_        out        m_tvalid/m_tready    tdata: record fields, tlast: last_record
// cfg_      in         cfg_we               cfg_wdata: core_clock_hz
//
// A begin item is stored as it is accepted; an end item reads its section's stores on
// acceptance and writes them back in ST_END_UPD. The stores are read and written back
// through a registered-read memory. A tick takes cycles per microsecond from a reciprocal
// multiply and runs the other divisions on one shared restoring divider of
// D = 42 + log2(N) bits for N sections, one quotient bit per cycle; output stalls extend a tick.
// Reset clears all statistics at once through per-section valid bits.
// No item is taken while a tick is in progress; the last record may wait in the output
// register while the next item is accepted.
module section_cycle_profiler_unit #(
  parameter int unsigned NumSections = scp_pkg::NumSectionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // op [1:0], section_id [9:2], now_cycles [41:10], zero [47:42]
  input  logic [scp_pkg::InDataW-1:0]   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // out_section [5:0], last_us [37:6], max_us [69:38], calls_in_second [101:70],
  // section_load [117:102], total_load [127:118]
  output logic [scp_pkg::OutDataW-1:0]  m_tdata_o,
  output logic                          m_tlast_o
);

  import scp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scp_ctrl #(
    .NumSections (NumSections)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scp_datapath #(
    .NumSections (NumSections)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_no_take_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> !s_tready_o)
    else $error("input ready during a division");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  a_last_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load && cmd.out_last |=> m_tvalid_o && m_tlast_o)
    else $error("final record not presented");
`endif

endmodule

// ===== bench/tb_section_cycle_profiler_unit.sv =====
`timescale 1ns / 100ps

module tb_section_cycle_profiler_unit;

  import scp_pkg::*;

  localparam int unsigned NUM_SECTIONS = NumSectionsDef;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned PHASE_ITEMS  = 32;

  typedef struct packed {
    logic [9:0]  total_load;
    logic [15:0] section_load;
    logic [31:0] calls_in_second;
    logic [31:0] max_us;
    logic [31:0] last_us;
    logic [5:0]  section;
  } stats_word_t;

  typedef struct {
    stats_word_t word;
    logic        last_record;
  } stats_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [31:0]           cfg_wdata_i = '0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [InDataW-1:0]    s_tdata_i = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_tdata_o;
  logic                  m_tlast_o;

  logic [31:0] clock_hz;
  logic [31:0] stamp_at_begin [NUM_SECTIONS];
  logic [31:0] recent_cycles [NUM_SECTIONS];
  logic [31:0] peak_cycles [NUM_SECTIONS];
  logic [31:0] busy_cycles [NUM_SECTIONS];
  logic [31:0] call_count [NUM_SECTIONS];
  stats_rec_t  expected_stats [$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned records_checked = 0;
  int unsigned clock_writes = 0;
  int unsigned cycle_count = 0;

  section_cycle_profiler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d records outstanding.",
               cycle_count, expected_stats.size());
      $display("section_cycle_profiler_unit verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] cycles_to_us(input logic [31:0] cycles);
    logic [31:0] per_us;
    per_us = clock_hz / CyclesPerUs;
    if (per_us == 32'd0) begin
      return 32'd0;
    end
    return cycles / per_us;
  endfunction

  function automatic logic [63:0] to_permille(input logic [63:0] cycles);
    if (clock_hz == 32'd0) begin
      return 64'd0;
    end
    return (cycles * 64'd1000) / {32'd0, clock_hz};
  endfunction

  task automatic clear_profile();
    int unsigned i;
    clock_hz = ClkHzReset;
    for (i = 0; i < NUM_SECTIONS; i++) begin
      stamp_at_begin[i] = '0;
      recent_cycles[i] = '0;
      peak_cycles[i] = '0;
      busy_cycles[i] = '0;
      call_count[i] = '0;
    end
  endtask

  task automatic update_profile(input logic [1:0] op, input logic [7:0] sec,
                                input logic [31:0] now);
    logic [31:0] elapsed;
    logic [63:0] busy_sum;
    logic [63:0] all_load;
    logic [63:0] one_load;
    stats_rec_t  rec;
    int unsigned i;
    if (op == OP_BEGIN) begin
      if (sec < NUM_SECTIONS) begin
        stamp_at_begin[sec] = now;
      end
    end else if (op == OP_END) begin
      if (sec < NUM_SECTIONS) begin
        elapsed = now - stamp_at_begin[sec];
        recent_cycles[sec] = elapsed;
        if (elapsed > peak_cycles[sec]) begin
          peak_cycles[sec] = elapsed;
        end
        busy_cycles[sec] = busy_cycles[sec] + elapsed;
        call_count[sec] = call_count[sec] + 32'd1;
      end
    end else if (op == OP_TICK) begin
      busy_sum = '0;
      for (i = 0; i < NUM_SECTIONS; i++) begin
        busy_sum = busy_sum + {32'd0, busy_cycles[i]};
      end
      all_load = to_permille(busy_sum);
      if (all_load > {54'd0, TotalLoadMax}) begin
        all_load = {54'd0, TotalLoadMax};
      end
      for (i = 0; i < NUM_SECTIONS; i++) begin
        one_load = to_permille({32'd0, busy_cycles[i]});
        if (one_load > {48'd0, SectionLoadMax}) begin
          one_load = {48'd0, SectionLoadMax};
        end
        rec.word.section = i[5:0];
        rec.word.last_us = cycles_to_us(recent_cycles[i]);
        rec.word.max_us = cycles_to_us(peak_cycles[i]);
        rec.word.calls_in_second = call_count[i];
        rec.word.section_load = one_load[15:0];
        rec.word.total_load = all_load[9:0];
        rec.last_record = (i == NUM_SECTIONS - 1);
        expected_stats.push_back(rec);
        busy_cycles[i] = '0;
        call_count[i] = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    stats_word_t seen;
    stats_rec_t  want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      seen = m_tdata_o;
      if (expected_stats.size() == 0) begin
        $error("Unexpected record for section %0d.", seen.section);
        fail_count++;
      end else begin
        want = expected_stats.pop_front();
        check_field("out_section", 32'(want.word.section), 32'(seen.section));
        check_field("last_us", want.word.last_us, seen.last_us);
        check_field("max_us", want.word.max_us, seen.max_us);
        check_field("calls_in_second", want.word.calls_in_second, seen.calls_in_second);
        check_field("section_load", 32'(want.word.section_load), 32'(seen.section_load));
        check_field("total_load", 32'(want.word.total_load), 32'(seen.total_load));
        check_field("last_record", 32'(want.last_record), 32'(m_tlast_o));
        records_checked++;
      end
    end
  end

  task automatic send_event(input logic [1:0] op, input logic [7:0] sec,
                            input logic [31:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i = {6'd0, now, sec, op};
    @(posedge clk_i);
    while (!s_tready_o) begin
      @(posedge clk_i);
    end
    update_profile(op, sec, now);
    if (op == OP_TICK) begin
      ticks_sent++;
    end
    items_sent++;
  endtask

  task automatic wait_for_records();
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    while (expected_stats.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_clock(input logic [31:0] hz);
    wait_for_records();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = hz;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    clock_hz = hz;
    clock_writes++;
  endtask

  function automatic logic [31:0] pick_duration();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(5000);
      6, 7:             return $urandom_range(32'h000F_FFFF);
      8:                return $urandom_range(32'h0FFF_FFFF);
      default:          return $urandom;
    endcase
  endfunction

  task automatic test_tick_after_reset();
    send_event(OP_END, 8'd3, 32'd5);
    send_event(OP_TICK, 8'hFF, $urandom);
  endtask

  task automatic test_section_pairs();
    send_event(OP_BEGIN, 8'd0, 32'hFFFF_FFF0);
    send_event(OP_END, 8'd0, 32'h0000_0010);
    send_event(OP_BEGIN, 8'd7, 32'h0000_0000);
    send_event(OP_END, 8'd7, 32'hFFFF_FFFF);
    send_event(OP_BEGIN, 8'd5, 32'hA5A5_A5A5);
    send_event(OP_END, 8'd5, 32'h5A5A_5A5A);
    send_event(OP_BEGIN, 8'd2, 32'h0000_1000);
    send_event(OP_END, 8'd2, 32'h0000_1000);
    send_event(OP_TICK, 8'd0, 32'd0);
  endtask

  task automatic test_ignored_items();
    send_event(OP_BEGIN, NUM_SECTIONS[7:0], 32'd77);
    send_event(OP_END, 8'hFF, 32'hFFFF_FFFF);
    send_event(OP_UNUSED, 8'd1, 32'h1234_5678);
    send_event(OP_END, 8'h80, 32'd9);
    send_event(OP_TICK, 8'h55, 32'hFFFF_FFFF);
  endtask

  task automatic test_clock_extremes();
    write_clock(32'd1000);
    send_event(OP_BEGIN, 8'd4, 32'd0);
    send_event(OP_END, 8'd4, 32'd100000);
    send_event(OP_TICK, 8'd0, 32'd0);
    write_clock(32'd0);
    send_event(OP_BEGIN, 8'd6, 32'd10);
    send_event(OP_END, 8'd6, 32'd5000010);
    send_event(OP_TICK, 8'd0, 32'd0);
    write_clock(32'hFFFF_FFFF);
    send_event(OP_TICK, 8'd0, 32'd0);
    write_clock(CyclesPerUs);
    send_event(OP_TICK, 8'd0, 32'd0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] clocks [8];
    logic [31:0] stamp;
    logic [7:0]  sec;
    int unsigned phase;
    int unsigned counted;
    int unsigned pick;
    clocks[0] = ClkHzReset;
    clocks[1] = 32'd1;
    clocks[2] = 32'd999999;
    clocks[3] = CyclesPerUs;
    clocks[4] = 32'd0;
    clocks[5] = 32'hFFFF_FFFF;
    clocks[6] = $urandom;
    clocks[7] = 32'd50000000;
    for (phase = 0; phase < 8; phase++) begin
      write_clock(clocks[phase]);
      case (phase / 2)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 66) begin
          sec = 8'($urandom_range(NUM_SECTIONS - 1));
          stamp = $urandom;
          send_event(OP_BEGIN, sec, stamp);
          send_event(OP_END, sec, stamp + pick_duration());
          counted += 2;
        end else if (pick < 76) begin
          if ($urandom_range(3) == 0) begin
            wait_for_records();
          end
          send_event(OP_TICK, 8'($urandom_range(255)), $urandom);
          counted++;
        end else if (pick < 86) begin
          send_event(OP_END, 8'($urandom_range(NUM_SECTIONS - 1)), $urandom);
          counted++;
        end else if (pick < 93) begin
          send_event($urandom_range(1) ? OP_END : OP_BEGIN,
                     8'($urandom_range(255, NUM_SECTIONS)), $urandom);
          counted++;
        end else begin
          send_event(OP_UNUSED, 8'($urandom_range(255)), $urandom);
          counted++;
        end
      end
    end
    send_event(OP_TICK, 8'd0, $urandom);
  endtask

  initial begin
    clear_profile();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_tick_after_reset();
    test_section_pairs();
    test_ignored_items();
    test_clock_extremes();
    test_random_traffic();

    wait_for_records();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d items including %0d update ticks under %0d clock settings.",
             items_sent, ticks_sent, clock_writes);
    $display("Checked %0d statistics records with %0d mismatches.",
             records_checked, fail_count);
    if (fail_count == 0) begin
      $display("section_cycle_profiler_unit verification clean");
    end else begin
      $display("section_cycle_profiler_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== section_cycle_profiler_unit.f =====
hw/rtl/scp_pkg.sv
hw/rtl/scp_ram.sv
hw/rtl/scp_div.sv
hw/rtl/scp_datapath.sv
hw/rtl/scp_ctrl.sv
hw/rtl/section_cycle_profiler_unit.sv
bench/tb_section_cycle_profiler_unit.sv
